FILE: rtl/vps_pkg.sv
// shared widths and types for the vector projection split block
`default_nettype none

package vps_pkg;

  // input component and result component widths
  localparam int CompW = 16;
  localparam int OutW  = 17;

  // first cross product: 16x16 products and their difference
  localparam int ProdW  = 32;
  localparam int CrossW = 33;

  // second cross product: 16x33 products and their difference
  localparam int TProdW = 49;
  localparam int TW     = 50;

  // squared field magnitude and divider widths
  localparam int QW    = 32;
  localparam int MagW  = 48;
  localparam int QuotW = 16;

  typedef logic signed [CompW-1:0]  comp_t;
  typedef logic signed [OutW-1:0]   out_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [CrossW-1:0] cross_t;
  typedef logic signed [TProdW-1:0] tprod_t;
  typedef logic signed [TW-1:0]     tvec_t;
  typedef logic [QW-1:0]            sqr_t;
  typedef logic [QuotW-1:0]         quot_t;

endpackage

`default_nettype wire

FILE: rtl/vps_if.sv
// request and result channel interfaces
`default_nettype none

interface vps_in_if;
  logic          valid;
  logic          ready;
  vps_pkg::comp_t vel_x;
  vps_pkg::comp_t vel_y;
  vps_pkg::comp_t vel_z;
  vps_pkg::comp_t fld_x;
  vps_pkg::comp_t fld_y;
  vps_pkg::comp_t fld_z;

  modport source (output valid, output vel_x, output vel_y, output vel_z,
                  output fld_x, output fld_y, output fld_z, input ready);
  modport sink   (input valid, input vel_x, input vel_y, input vel_z,
                  input fld_x, input fld_y, input fld_z, output ready);
endinterface

interface vps_out_if;
  logic          valid;
  logic          ready;
  vps_pkg::out_t par_x;
  vps_pkg::out_t par_y;
  vps_pkg::out_t par_z;
  vps_pkg::out_t perp_x;
  vps_pkg::out_t perp_y;
  vps_pkg::out_t perp_z;
  logic          zero_field;

  modport source (output valid, output par_x, output par_y, output par_z,
                  output perp_x, output perp_y, output perp_z,
                  output zero_field, input ready);
  modport sink   (input valid, input par_x, input par_y, input par_z,
                  input perp_x, input perp_y, input perp_z,
                  input zero_field, output ready);
endinterface

`default_nettype wire

FILE: rtl/vps_front.sv
// front end: both cross products and the squared field magnitude, four stages
`default_nettype none

module vps_front (
  input  wire                    clk_i,
  input  wire  [3:0]             en_i,
  input  vps_pkg::comp_t         vel_i [3],
  input  vps_pkg::comp_t         fld_i [3],
  output vps_pkg::tvec_t         t_o   [3],
  output vps_pkg::sqr_t          q_o,
  output logic                   zero_o
);

  // stage 1 registers
  vps_pkg::prod_t  pa_q [3];
  vps_pkg::prod_t  pb_q [3];
  vps_pkg::prod_t  sq_q [3];
  vps_pkg::comp_t  b1_q [3];
  vps_pkg::prod_t  pa_d [3];
  vps_pkg::prod_t  pb_d [3];
  vps_pkg::prod_t  sq_d [3];

  // stage 2 registers
  vps_pkg::cross_t w_q  [3];
  vps_pkg::cross_t w_d  [3];
  vps_pkg::comp_t  b2_q [3];
  vps_pkg::sqr_t   q2_q, q2_d;
  logic            z2_q;

  // stage 3 registers
  vps_pkg::tprod_t ta_q [3];
  vps_pkg::tprod_t tb_q [3];
  vps_pkg::tprod_t ta_d [3];
  vps_pkg::tprod_t tb_d [3];
  vps_pkg::sqr_t   q3_q;
  logic            z3_q;

  // stage 4 registers
  vps_pkg::tvec_t  t_q [3];
  vps_pkg::tvec_t  t_d [3];
  vps_pkg::sqr_t   q4_q;
  logic            z4_q;

  for (genvar i = 0; i < 3; i++) begin : g_comp
    localparam int I1 = (i + 1) % 3;
    localparam int I2 = (i + 2) % 3;

    // products for w = v x b and the field squares
    always_comb begin
      pa_d[i] = vps_pkg::ProdW'(vel_i[I1]) * vps_pkg::ProdW'(fld_i[I2]);
      pb_d[i] = vps_pkg::ProdW'(vel_i[I2]) * vps_pkg::ProdW'(fld_i[I1]);
      sq_d[i] = vps_pkg::ProdW'(fld_i[i]) * vps_pkg::ProdW'(fld_i[i]);
    end

    // w component
    always_comb begin
      w_d[i] = vps_pkg::CrossW'(pa_q[i]) - vps_pkg::CrossW'(pb_q[i]);
    end

    // products for t = b x w
    always_comb begin
      ta_d[i] = vps_pkg::TProdW'(b2_q[I1]) * vps_pkg::TProdW'(w_q[I2]);
      tb_d[i] = vps_pkg::TProdW'(b2_q[I2]) * vps_pkg::TProdW'(w_q[I1]);
    end

    // t component
    always_comb begin
      t_d[i] = vps_pkg::TW'(ta_q[i]) - vps_pkg::TW'(tb_q[i]);
    end
  end

  // squared magnitude, squares are never negative
  always_comb begin
    q2_d = unsigned'(sq_q[0]) + unsigned'(sq_q[1]) + unsigned'(sq_q[2]);
  end

  // pipeline registers
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
      sq_q <= sq_d;
      b1_q <= fld_i;
    end
    if (en_i[1]) begin
      w_q  <= w_d;
      b2_q <= b1_q;
      q2_q <= q2_d;
      z2_q <= (q2_d == '0);
    end
    if (en_i[2]) begin
      ta_q <= ta_d;
      tb_q <= tb_d;
      q3_q <= q2_q;
      z3_q <= z2_q;
    end
    if (en_i[3]) begin
      t_q  <= t_d;
      q4_q <= q3_q;
      z4_q <= z3_q;
    end
  end

  assign t_o    = t_q;
  assign q_o    = q4_q;
  assign zero_o = z4_q;

endmodule

`default_nettype wire

FILE: rtl/vps_div.sv
// pipelined restoring divider, three lanes sharing one divisor
`default_nettype none

module vps_div #(
  parameter int StepsPerStage = 2
) (
  input  wire                             clk_i,
  input  wire  [vps_pkg::QuotW/StepsPerStage:0] en_i,
  input  vps_pkg::tvec_t                  t_i [3],
  input  vps_pkg::sqr_t                   q_i,
  output vps_pkg::quot_t                  quot_o [3],
  output logic [2:0]                      neg_o
);

  localparam int NStg = vps_pkg::QuotW / StepsPerStage;
  localparam int QW   = vps_pkg::QW;
  localparam int QtW  = vps_pkg::QuotW;

  // stage 0 is magnitude and sign, stages 1..NStg each retire some quotient bits
  logic [QW-1:0]   rem_q [NStg+1][3];
  logic [QW-1:0]   rem_d [NStg+1][3];
  vps_pkg::quot_t  lo_q  [NStg+1][3];
  vps_pkg::quot_t  lo_d  [NStg+1][3];
  vps_pkg::quot_t  qu_q  [NStg+1][3];
  vps_pkg::quot_t  qu_d  [NStg+1][3];
  logic [2:0]      neg_q [NStg+1];
  vps_pkg::sqr_t   dv_q  [NStg+1];

  // magnitude split into the high remainder and the low dividend bits
  always_comb begin : mag_comb
    logic [vps_pkg::TW-1:0] mag;
    for (int c = 0; c < 3; c++) begin
      mag = t_i[c][vps_pkg::TW-1] ? vps_pkg::TW'(-t_i[c]) : vps_pkg::TW'(t_i[c]);
      rem_d[0][c] = mag[vps_pkg::MagW-1:QtW];
      lo_d[0][c]  = mag[QtW-1:0];
      qu_d[0][c]  = '0;
    end
  end

  for (genvar s = 1; s <= NStg; s++) begin : g_stage
    // shift, compare and subtract for this stage's quotient bits
    always_comb begin : step_comb
      logic [QW:0]    r2;
      logic [QW-1:0]  r;
      vps_pkg::quot_t lo;
      vps_pkg::quot_t qu;
      for (int c = 0; c < 3; c++) begin
        r  = rem_q[s-1][c];
        lo = lo_q[s-1][c];
        qu = qu_q[s-1][c];
        for (int k = 0; k < StepsPerStage; k++) begin
          r2 = {r, lo[QtW-1]};
          if (r2 >= {1'b0, dv_q[s-1]}) begin
            r  = QW'(r2 - {1'b0, dv_q[s-1]});
            qu = {qu[QtW-2:0], 1'b1};
          end else begin
            r  = r2[QW-1:0];
            qu = {qu[QtW-2:0], 1'b0};
          end
          lo = {lo[QtW-2:0], 1'b0};
        end
        rem_d[s][c] = r;
        lo_d[s][c]  = lo;
        qu_d[s][c]  = qu;
      end
    end
  end

  // pipeline registers
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= rem_d[0];
      lo_q[0]  <= lo_d[0];
      qu_q[0]  <= qu_d[0];
      neg_q[0] <= {t_i[2][vps_pkg::TW-1], t_i[1][vps_pkg::TW-1], t_i[0][vps_pkg::TW-1]};
      dv_q[0]  <= q_i;
    end
    for (int s = 1; s <= NStg; s++) begin
      if (en_i[s]) begin
        rem_q[s] <= rem_d[s];
        lo_q[s]  <= lo_d[s];
        qu_q[s]  <= qu_d[s];
        neg_q[s] <= neg_q[s-1];
        dv_q[s]  <= dv_q[s-1];
      end
    end
  end

  assign quot_o = qu_q[NStg];
  assign neg_o  = neg_q[NStg];

endmodule

`default_nettype wire

FILE: rtl/vps_back.sv
// output stage: signed perpendicular part, parallel part and zero-field masking
`default_nettype none

module vps_back (
  input  wire                  clk_i,
  input  wire                  en_i,
  input  vps_pkg::quot_t       quot_i [3],
  input  wire  [2:0]           neg_i,
  input  vps_pkg::comp_t       vel_i  [3],
  input  wire                  zero_i,
  output vps_pkg::out_t        par_o  [3],
  output vps_pkg::out_t        perp_o [3],
  output logic                 zero_o
);

  vps_pkg::out_t par_q  [3];
  vps_pkg::out_t perp_q [3];
  vps_pkg::out_t par_d  [3];
  vps_pkg::out_t perp_d [3];
  logic          zero_q;

  // restore sign, subtract from velocity, force zero for a null field
  always_comb begin : res_comb
    vps_pkg::out_t mag;
    vps_pkg::out_t perp;
    for (int c = 0; c < 3; c++) begin
      mag  = vps_pkg::out_t'({1'b0, quot_i[c]});
      perp = neg_i[c] ? vps_pkg::out_t'(-mag) : mag;
      if (zero_i) begin
        perp_d[c] = '0;
        par_d[c]  = '0;
      end else begin
        perp_d[c] = perp;
        par_d[c]  = vps_pkg::out_t'(vps_pkg::OutW'(vel_i[c]) - perp);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      par_q  <= par_d;
      perp_q <= perp_d;
      zero_q <= zero_i;
    end
  end

  assign par_o  = par_q;
  assign perp_o = perp_q;
  assign zero_o = zero_q;

endmodule

`default_nettype wire

FILE: rtl/vector_projection_split.sv
// Splits a velocity vector into its parts along and across a field vector.
// One request is taken every clock cycle unless the pipeline is full and a
// finished result is not taken. The restoring divider forms t/|B|^2 for all
// three components in parallel: it retires DivStepsPerStage quotient bits
// per pipeline stage over 16 bits, behind four stages of cross products and
// one magnitude stage, with one output register at the end. Every stage
// carries its own valid bit and holds when the stage after it is full and
// stalled, so bubbles are squeezed out and requests keep flowing into empty
// stages while a finished result waits. A zero field gives zero_field set
// and all components zero.
`default_nettype none

module vector_projection_split #(
  parameter int DivStepsPerStage = 2
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  vps_in_if.sink       req_i,
  vps_out_if.source    res_o
);

  localparam int DivStages = vps_pkg::QuotW / DivStepsPerStage;
  localparam int DivFirst  = 4;
  localparam int NStages   = DivFirst + DivStages + 2;
  localparam int LastPre   = NStages - 2;

  logic [NStages-1:0] valid_q;
  logic [NStages-1:0] en;

  vps_pkg::comp_t vel_in [3];
  vps_pkg::comp_t fld_in [3];
  vps_pkg::comp_t vd_q   [NStages-1][3];
  logic           zd_q   [DivFirst:LastPre];

  vps_pkg::tvec_t t_w [3];
  vps_pkg::sqr_t  q_w;
  logic           zero_w;
  vps_pkg::quot_t quot_w [3];
  logic [2:0]     neg_w;
  vps_pkg::out_t  par_w  [3];
  vps_pkg::out_t  perp_w [3];
  logic           zfld_w;

  assign vel_in[0] = req_i.vel_x;
  assign vel_in[1] = req_i.vel_y;
  assign vel_in[2] = req_i.vel_z;
  assign fld_in[0] = req_i.fld_x;
  assign fld_in[1] = req_i.fld_y;
  assign fld_in[2] = req_i.fld_z;

  // a stage moves when it is empty or the stage after it moves
  always_comb begin
    en[NStages-1] = ~valid_q[NStages-1] | res_o.ready;
    for (int k = NStages - 2; k >= 0; k--) begin
      en[k] = ~valid_q[k] | en[k+1];
    end
  end

  assign req_i.ready = en[0];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= req_i.valid;
      end
      for (int k = 1; k < NStages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // velocity and zero-field flag travel alongside the arithmetic
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      vd_q[0] <= vel_in;
    end
    for (int k = 1; k <= LastPre; k++) begin
      if (en[k]) begin
        vd_q[k] <= vd_q[k-1];
      end
    end
    if (en[DivFirst]) begin
      zd_q[DivFirst] <= zero_w;
    end
    for (int k = DivFirst + 1; k <= LastPre; k++) begin
      if (en[k]) begin
        zd_q[k] <= zd_q[k-1];
      end
    end
  end

  vps_front u_front (
    .clk_i  (clk_i),
    .en_i   (en[3:0]),
    .vel_i  (vel_in),
    .fld_i  (fld_in),
    .t_o    (t_w),
    .q_o    (q_w),
    .zero_o (zero_w)
  );

  vps_div #(
    .StepsPerStage (DivStepsPerStage)
  ) u_div (
    .clk_i  (clk_i),
    .en_i   (en[DivFirst +: DivStages + 1]),
    .t_i    (t_w),
    .q_i    (q_w),
    .quot_o (quot_w),
    .neg_o  (neg_w)
  );

  vps_back u_back (
    .clk_i  (clk_i),
    .en_i   (en[NStages-1]),
    .quot_i (quot_w),
    .neg_i  (neg_w),
    .vel_i  (vd_q[LastPre]),
    .zero_i (zd_q[LastPre]),
    .par_o  (par_w),
    .perp_o (perp_w),
    .zero_o (zfld_w)
  );

  assign res_o.valid      = valid_q[NStages-1];
  assign res_o.par_x      = par_w[0];
  assign res_o.par_y      = par_w[1];
  assign res_o.par_z      = par_w[2];
  assign res_o.perp_x     = perp_w[0];
  assign res_o.perp_y     = perp_w[1];
  assign res_o.perp_z     = perp_w[2];
  assign res_o.zero_field = zfld_w;

endmodule

`default_nettype wire

FILE: test/vector_projection_split_tb.sv
// testbench for vector_projection_split: directed and random vector pairs checked in order
`default_nettype none

module vector_projection_split_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef vps_pkg::comp_t comp_vec_t[3];

  // one split as the block returns it
  typedef struct {
    vps_pkg::out_t par[3];
    vps_pkg::out_t perp[3];
    logic          zero_field;
  } split_t;

  // predicts each split and checks results in arrival order
  class projection_scoreboard;
    split_t pending_splits[$];
    int     mismatches;

    function new();
      mismatches = 0;
    endfunction

    // exact integer split: perp = B x (v x B) / |B|^2, par = v - perp
    function split_t predict_split(comp_vec_t vel, comp_vec_t fld);
      split_t s;
      longint v[3];
      longint b[3];
      longint w[3];
      longint t[3];
      longint mag_sq;
      longint perp;
      for (int i = 0; i < 3; i++) begin
        v[i] = vel[i];
        b[i] = fld[i];
      end
      mag_sq = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
      s.zero_field = (mag_sq == 0);
      w[0] = v[1] * b[2] - v[2] * b[1];
      w[1] = v[2] * b[0] - v[0] * b[2];
      w[2] = v[0] * b[1] - v[1] * b[0];
      t[0] = b[1] * w[2] - b[2] * w[1];
      t[1] = b[2] * w[0] - b[0] * w[2];
      t[2] = b[0] * w[1] - b[1] * w[0];
      for (int i = 0; i < 3; i++) begin
        if (s.zero_field) begin
          s.par[i]  = '0;
          s.perp[i] = '0;
        end else begin
          // longint division truncates toward zero
          perp      = t[i] / mag_sq;
          s.perp[i] = vps_pkg::out_t'(perp);
          s.par[i]  = vps_pkg::out_t'(v[i] - perp);
        end
      end
      return s;
    endfunction

    function void add_request(comp_vec_t vel, comp_vec_t fld);
      pending_splits.push_back(predict_split(vel, fld));
    endfunction

    function int pending();
      return pending_splits.size();
    endfunction

    function void report(string what, longint exp_val, longint act_val);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_val, act_val);
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_split(split_t act);
      split_t exp_s;
      string  axis;
      if (pending_splits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request outstanding", $time);
        return;
      end
      exp_s = pending_splits.pop_front();
      for (int i = 0; i < 3; i++) begin
        axis = (i == 0) ? "x" : (i == 1) ? "y" : "z";
        if (act.par[i] !== exp_s.par[i])
          report({"par_", axis}, exp_s.par[i], act.par[i]);
        if (act.perp[i] !== exp_s.perp[i])
          report({"perp_", axis}, exp_s.perp[i], act.perp[i]);
      end
      if (act.zero_field !== exp_s.zero_field)
        report("zero_field", exp_s.zero_field, act.zero_field);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  vps_in_if  req_if ();
  vps_out_if res_if ();

  vector_projection_split i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  projection_scoreboard board;
  int send_idle_pct;
  int recv_stall_pct;

  // clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic bit roll(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // inputs known from the start
  initial begin
    board          = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    req_if.valid   = 1'b0;
    req_if.vel_x   = '0;
    req_if.vel_y   = '0;
    req_if.vel_z   = '0;
    req_if.fld_x   = '0;
    req_if.fld_y   = '0;
    req_if.fld_z   = '0;
    res_if.ready   = 1'b0;
  end

  // receiver stalls, changed at the falling edge
  always @(negedge clk_i) begin
    res_if.ready = rst_ni && !roll(recv_stall_pct);
  end

  // result monitor
  initial begin
    split_t act;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        act.par[0]     = res_if.par_x;
        act.par[1]     = res_if.par_y;
        act.par[2]     = res_if.par_z;
        act.perp[0]    = res_if.perp_x;
        act.perp[1]    = res_if.perp_y;
        act.perp[2]    = res_if.perp_z;
        act.zero_field = res_if.zero_field;
        board.check_split(act);
      end
    end
  end

  // present one request, with random idle cycles in front, until accepted
  task automatic send_request(vps_pkg::comp_t vx, vps_pkg::comp_t vy, vps_pkg::comp_t vz,
                              vps_pkg::comp_t fx, vps_pkg::comp_t fy, vps_pkg::comp_t fz);
    comp_vec_t vel;
    comp_vec_t fld;
    vel = '{vx, vy, vz};
    fld = '{fx, fy, fz};
    while (roll(send_idle_pct)) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.vel_x = vx;
    req_if.vel_y = vy;
    req_if.vel_z = vz;
    req_if.fld_x = fx;
    req_if.fld_y = fy;
    req_if.fld_z = fz;
    req_if.valid = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    board.add_request(vel, fld);
    @(negedge clk_i);
  endtask

  // hold off the sender until every outstanding split is back
  task automatic drain_splits();
    req_if.valid = 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
  endtask

  // component mix: full range, near zero, extremes and zero
  function automatic vps_pkg::comp_t rand_comp();
    case ($urandom_range(9, 0))
      4, 5:    return vps_pkg::comp_t'(int'($urandom_range(16, 0)) - 8);
      6:       return $urandom_range(1, 0) ? vps_pkg::comp_t'(16'sh7fff)
                                           : vps_pkg::comp_t'(16'sh8000);
      7:       return '0;
      default: return vps_pkg::comp_t'($urandom);
    endcase
  endfunction

  task automatic send_random();
    vps_pkg::comp_t fx;
    vps_pkg::comp_t fy;
    vps_pkg::comp_t fz;
    fx = rand_comp();
    fy = rand_comp();
    fz = rand_comp();
    // a zero field now and then
    if ($urandom_range(19, 0) == 0) begin
      fx = '0;
      fy = '0;
      fz = '0;
    end
    send_request(rand_comp(), rand_comp(), rand_comp(), fx, fy, fz);
  endtask

  // main sequence
  initial begin
    int stall_mix[4][2];
    stall_mix = '{'{0, 0}, '{79, 0}, '{0, 79}, '{9, 9}};
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: zero field, extremes, parallel and perpendicular cases
    send_request(16'sh7fff, 16'sh8000, 1234, 0, 0, 0);
    send_request(0, 0, 0, 0, 0, 0);
    send_request(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_request(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000);
    send_request(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send_request(100, 0, 0, 0, 0, 1);
    send_request(300, 600, 900, 1, 2, 3);
    send_request(16'sh8000, 16'sh7fff, -1, 1, 0, 0);
    send_request(5, -7, 11, 0, 16'sh8000, 0);
    send_request(-1, -1, -1, -1, -1, -1);
    send_request(1, 1, 1, 0, 0, -1);
    send_request(16'sh7fff, 0, 16'sh8000, 3, -3, 1);
    send_request(16'sh8000, 16'sh8000, 16'sh8000, 1, 1, 1);
    send_request(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_request(16'sh8000, 0, 16'sh7fff, 0, 16'sh8000, 16'sh8000);
    drain_splits();

    // random requests under each idling mix
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = stall_mix[p][0];
      recv_stall_pct = stall_mix[p][1];
      repeat (225) send_random();
      drain_splits();
    end

    // allow for any late stray result
    recv_stall_pct = 0;
    repeat (40) @(negedge clk_i);

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
